/* hw/rtl/sadr_pkg.sv */
// ----------------------------------------------------------------------------
// sadr_pkg
// Shared types and codes for the slot allocator with deferred release.
// ----------------------------------------------------------------------------
`default_nettype none

package sadr_pkg;

	// default number of slots
	localparam int SLOTS_DEF = 64;

	// operation codes carried in the mode field
	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_RELEASE = 3'd1;
	localparam logic [2:0] MODE_FLUSH   = 3'd2;
	localparam logic [2:0] MODE_CLEAR   = 3'd3;
	localparam logic [2:0] MODE_LOOKUP  = 3'd4;
	localparam logic [2:0] MODE_PEEK    = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;
	localparam logic [1:0] STAT_QFULL   = 2'd3;

	// input beat
	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  slot_index;
		logic [31:0] object_handle;
	} item_t;

	// result beat
	typedef struct packed {
		logic [5:0]  result_slot;
		logic [31:0] handle_out;
		logic [1:0]  status;
		logic [6:0]  freed_count;
		logic [6:0]  free_count;
	} result_t;

	// write enables from the sequencer to the storage
	typedef struct packed {
		logic stk_we;
		logic vld_we;
		logic vld_wdata;
		logic hdl_we;
		logic rq_we;
	} mem_ctl_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ALLOC,
		S_PEEK,
		S_LOOKUP,
		S_FL_CHK,
		S_FL_RDQ,
		S_FL_RDV
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/slot_allocator_deferred_release.sv */
// ----------------------------------------------------------------------------
// slot_allocator_deferred_release
// Slot allocator with a LIFO free stack and a queue of deferred releases.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (item: mode, slot_index, object_handle) is taken at a
//   rising edge with start high and busy low. Exactly one result beat per
//   command appears on result for one cycle, marked by done; the receiver
//   must take it then, it cannot stall the block.
//   Steps from the accepting edge to done:
//     queue release, no-op modes, allocate/peek on an empty stack: decided at acceptance
//     allocate, peek, lookup: one registered memory read
//     flush: queue read, valid read, update per queued entry, then a check
//     clear: the clearing pass, one stack and valid entry rewritten per cycle
//   busy is high while a command walks the states; commands decided at
//   acceptance leave it low. All storage sits in single-port memories; the
//   sequencer makes one access to each per cycle.
//   After reset the block runs a clearing pass over all slots with busy
//   high and no result; then all slots are free with slot 0 on top.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_allocator_deferred_release
	import sadr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int SW = $clog2(SLOTS);

	mem_ctl_t      ctl;
	logic [SW-1:0] stk_addr, stk_wdata, slot_addr, rq_addr, rq_wdata;
	logic [31:0]   hdl_wdata;
	logic [SW-1:0] stk_rdata, rq_rdata;
	logic          vld_rdata;
	logic [31:0]   hdl_rdata;

	// command sequencer
	sadr_seq #(
		.SLOTS(SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ctl       (ctl),
		.stk_addr  (stk_addr),
		.stk_wdata (stk_wdata),
		.slot_addr (slot_addr),
		.hdl_wdata (hdl_wdata),
		.rq_addr   (rq_addr),
		.rq_wdata  (rq_wdata),
		.stk_rdata (stk_rdata),
		.vld_rdata (vld_rdata),
		.hdl_rdata (hdl_rdata),
		.rq_rdata  (rq_rdata)
	);

	// slot storage
	sadr_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.stk_addr  (stk_addr),
		.stk_wdata (stk_wdata),
		.slot_addr (slot_addr),
		.hdl_wdata (hdl_wdata),
		.rq_addr   (rq_addr),
		.rq_wdata  (rq_wdata),
		.stk_rdata (stk_rdata),
		.vld_rdata (vld_rdata),
		.hdl_rdata (hdl_rdata),
		.rq_rdata  (rq_rdata)
	);

endmodule

`default_nettype wire

/* hw/rtl/sadr_store.sv */
// ----------------------------------------------------------------------------
// sadr_store
// Slot storage: free stack, valid bits, handles and the release queue, each a
// single-port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sadr_store
	import sadr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire                          clk,
	input  mem_ctl_t                     ctl,
	input  wire  [$clog2(SLOTS)-1:0]     stk_addr,
	input  wire  [$clog2(SLOTS)-1:0]     stk_wdata,
	input  wire  [$clog2(SLOTS)-1:0]     slot_addr,
	input  wire  [31:0]                  hdl_wdata,
	input  wire  [$clog2(SLOTS)-1:0]     rq_addr,
	input  wire  [$clog2(SLOTS)-1:0]     rq_wdata,
	output logic [$clog2(SLOTS)-1:0]     stk_rdata,
	output logic                         vld_rdata,
	output logic [31:0]                  hdl_rdata,
	output logic [$clog2(SLOTS)-1:0]     rq_rdata
);

	localparam int SW = $clog2(SLOTS);

	logic [SW-1:0] stk_mem [SLOTS];
	logic          vld_mem [SLOTS];
	logic [31:0]   hdl_mem [SLOTS];
	logic [SW-1:0] rq_mem  [SLOTS];

	logic [SW-1:0] stk_rd_q;
	logic          vld_rd_q;
	logic [31:0]   hdl_rd_q;
	logic [SW-1:0] rq_rd_q;

	// free stack
	always_ff @(posedge clk) begin
		if (ctl.stk_we) begin
			stk_mem[stk_addr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_addr];
	end

	// valid bits, addressed by slot
	always_ff @(posedge clk) begin
		if (ctl.vld_we) begin
			vld_mem[slot_addr] <= ctl.vld_wdata;
		end
		vld_rd_q <= vld_mem[slot_addr];
	end

	// handles, addressed by slot
	always_ff @(posedge clk) begin
		if (ctl.hdl_we) begin
			hdl_mem[slot_addr] <= hdl_wdata;
		end
		hdl_rd_q <= hdl_mem[slot_addr];
	end

	// pending release queue
	always_ff @(posedge clk) begin
		if (ctl.rq_we) begin
			rq_mem[rq_addr] <= rq_wdata;
		end
		rq_rd_q <= rq_mem[rq_addr];
	end

	assign stk_rdata = stk_rd_q;
	assign vld_rdata = vld_rd_q;
	assign hdl_rdata = hdl_rd_q;
	assign rq_rdata  = rq_rd_q;

endmodule

`default_nettype wire

/* hw/rtl/sadr_seq.sv */
// ----------------------------------------------------------------------------
// sadr_seq
// Sequencer: takes one command beat, steps the storage through its memory
// accesses, keeps the stack and queue counters, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sadr_seq
	import sadr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  item_t                        item,
	output logic                         busy,
	output logic                         done,
	output result_t                      result,
	output mem_ctl_t                     ctl,
	output logic [$clog2(SLOTS)-1:0]     stk_addr,
	output logic [$clog2(SLOTS)-1:0]     stk_wdata,
	output logic [$clog2(SLOTS)-1:0]     slot_addr,
	output logic [31:0]                  hdl_wdata,
	output logic [$clog2(SLOTS)-1:0]     rq_addr,
	output logic [$clog2(SLOTS)-1:0]     rq_wdata,
	input  wire  [$clog2(SLOTS)-1:0]     stk_rdata,
	input  wire                          vld_rdata,
	input  wire  [31:0]                  hdl_rdata,
	input  wire  [$clog2(SLOTS)-1:0]     rq_rdata
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] free_top_q;
	logic [CW-1:0] rcount_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] freed_q;
	logic [SW-1:0] s_q;
	logic [5:0]    idx_q;
	logic [31:0]   obj_q;
	logic          clr_q;
	logic          done_q;
	result_t       result_q;

	// control pulses from the output decode
	logic    res_load;
	result_t res_d;
	logic    top_dec, top_inc, freed_inc, cnt_inc, cnt_clr;
	logic    rq_push, rq_clr, init_done, clr_set, item_take, s_take;

	// derived values
	logic [CW-1:0]   top_m1;
	logic [CW-1:0]   slots_c;
	logic [SW+5:0]   idx_in_ext;
	logic [SW-1:0]   idx_in_addr;
	logic            in_range_in, in_range_q;
	logic [CW+6:0]   ftop_ext, ftop_m1_ext, full_ext, freed_ext;
	logic [SW+5:0]   stk_rd_ext;
	logic [SW-1:0]   cnt_idx;
	logic            top_empty, top_room;

	assign slots_c     = CW'(SLOTS);
	assign top_m1      = free_top_q - 1'b1;
	assign idx_in_ext  = {{SW{1'b0}}, item.slot_index};
	assign idx_in_addr = idx_in_ext[SW-1:0];
	assign in_range_in = (32'(item.slot_index) < SLOTS);
	assign in_range_q  = (32'(idx_q) < SLOTS);
	assign ftop_ext    = {7'd0, free_top_q};
	assign ftop_m1_ext = {7'd0, top_m1};
	assign full_ext    = {7'd0, slots_c};
	assign freed_ext   = {7'd0, freed_q};
	assign stk_rd_ext  = {6'd0, stk_rdata};
	assign cnt_idx     = cnt_q[SW-1:0];
	assign top_empty   = (free_top_q == '0);
	assign top_room    = (free_top_q < slots_c);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (cnt_idx == SW'(SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (item.mode)
						MODE_ALLOC:  if (!top_empty) state_d = S_ALLOC;
						MODE_FLUSH:  state_d = S_FL_CHK;
						MODE_CLEAR:  state_d = S_INIT;
						MODE_LOOKUP: state_d = S_LOOKUP;
						MODE_PEEK:   if (!top_empty) state_d = S_PEEK;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC:  state_d = S_IDLE;
			S_PEEK:   state_d = S_IDLE;
			S_LOOKUP: state_d = S_IDLE;
			S_FL_CHK: begin
				if (cnt_q == rcount_q) state_d = S_IDLE;
				else                   state_d = S_FL_RDQ;
			end
			S_FL_RDQ: state_d = S_FL_RDV;
			S_FL_RDV: state_d = S_FL_CHK;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory accesses, counter pulses and result
	always_comb begin
		ctl       = '0;
		stk_addr  = top_m1[SW-1:0];
		stk_wdata = s_q;
		slot_addr = idx_in_addr;
		hdl_wdata = obj_q;
		rq_addr   = rcount_q[SW-1:0];
		rq_wdata  = idx_in_addr;
		res_load  = 1'b0;
		res_d     = '0;
		res_d.free_count = ftop_ext[6:0];
		top_dec   = 1'b0;
		top_inc   = 1'b0;
		freed_inc = 1'b0;
		cnt_inc   = 1'b0;
		cnt_clr   = 1'b0;
		rq_push   = 1'b0;
		rq_clr    = 1'b0;
		init_done = 1'b0;
		clr_set   = 1'b0;
		item_take = 1'b0;
		s_take    = 1'b0;
		unique case (state_q)
			// clearing pass: restore stack order and drop valid bits
			S_INIT: begin
				ctl.stk_we    = 1'b1;
				ctl.vld_we    = 1'b1;
				ctl.vld_wdata = 1'b0;
				stk_addr      = cnt_idx;
				stk_wdata     = SW'(SLOTS - 1) - cnt_idx;
				slot_addr     = cnt_idx;
				if (cnt_idx == SW'(SLOTS - 1)) begin
					init_done = 1'b1;
					cnt_clr   = 1'b1;
					if (clr_q) begin
						res_load         = 1'b1;
						res_d.free_count = full_ext[6:0];
					end
				end else begin
					cnt_inc = 1'b1;
				end
			end
			// dispatch a command beat
			S_IDLE: begin
				if (start) begin
					item_take = 1'b1;
					case (item.mode)
						MODE_ALLOC: begin
							if (top_empty) begin
								res_load     = 1'b1;
								res_d.status = STAT_EMPTY;
							end
						end
						MODE_RELEASE: begin
							res_load = 1'b1;
							if (!in_range_in) begin
								res_d.status = STAT_INVALID;
							end else if (rcount_q == slots_c) begin
								res_d.status = STAT_QFULL;
							end else begin
								ctl.rq_we = 1'b1;
								rq_push   = 1'b1;
							end
						end
						MODE_FLUSH: begin
							cnt_clr = 1'b1;
						end
						MODE_CLEAR: begin
							clr_set = 1'b1;
							cnt_clr = 1'b1;
						end
						MODE_LOOKUP: begin
						end
						MODE_PEEK: begin
							if (top_empty) begin
								res_load     = 1'b1;
								res_d.status = STAT_EMPTY;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			// top of stack is out: mark slot valid, store handle, pop
			S_ALLOC: begin
				ctl.vld_we        = 1'b1;
				ctl.vld_wdata     = 1'b1;
				ctl.hdl_we        = 1'b1;
				slot_addr         = stk_rdata;
				top_dec           = 1'b1;
				res_load          = 1'b1;
				res_d.result_slot = stk_rd_ext[5:0];
				res_d.free_count  = ftop_m1_ext[6:0];
			end
			S_PEEK: begin
				res_load          = 1'b1;
				res_d.result_slot = stk_rd_ext[5:0];
			end
			S_LOOKUP: begin
				res_load          = 1'b1;
				res_d.result_slot = idx_q;
				if (in_range_q && vld_rdata) res_d.handle_out = hdl_rdata;
				else                         res_d.status     = STAT_INVALID;
			end
			// flush walk: fetch next queued entry or finish
			S_FL_CHK: begin
				rq_addr = cnt_idx;
				if (cnt_q == rcount_q) begin
					rq_clr            = 1'b1;
					res_load          = 1'b1;
					res_d.freed_count = freed_ext[6:0];
				end
			end
			S_FL_RDQ: begin
				slot_addr = rq_rdata;
				s_take    = 1'b1;
			end
			// free the slot only if still valid
			S_FL_RDV: begin
				slot_addr = s_q;
				cnt_inc   = 1'b1;
				if (vld_rdata) begin
					ctl.vld_we    = 1'b1;
					ctl.vld_wdata = 1'b0;
					freed_inc     = 1'b1;
					if (top_room) begin
						ctl.stk_we = 1'b1;
						stk_addr   = free_top_q[SW-1:0];
						stk_wdata  = s_q;
						top_inc    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			free_top_q <= CW'(SLOTS);
			rcount_q   <= '0;
			cnt_q      <= '0;
			freed_q    <= '0;
			clr_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (init_done) begin
				free_top_q <= slots_c;
			end else if (top_dec) begin
				free_top_q <= top_m1;
			end else if (top_inc) begin
				free_top_q <= free_top_q + 1'b1;
			end
			if (init_done || rq_clr) begin
				rcount_q <= '0;
			end else if (rq_push) begin
				rcount_q <= rcount_q + 1'b1;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cnt_clr) begin
				freed_q <= '0;
			end else if (freed_inc) begin
				freed_q <= freed_q + 1'b1;
			end
			if (clr_set) begin
				clr_q <= 1'b1;
			end else if (init_done) begin
				clr_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_take) begin
			idx_q <= item.slot_index;
			obj_q <= item.object_handle;
		end
		if (s_take) begin
			s_q <= rq_rdata;
		end
		if (res_load) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire
